// File: rtl/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and constants of the power rail sequencer.
// ----------------------------------------------------------------------------
package prs_pkg;

   localparam int COUNTER_WIDTH_DEF = 16;
   localparam int RAIL_COUNT        = 4;
   localparam int RAIL_W            = $clog2(RAIL_COUNT);
   localparam int CFG_W             = 16;
   localparam int CSR_IDX_W         = 4;

   localparam logic [RAIL_W-1:0] RAIL_MAIN     = RAIL_W'(0);
   localparam logic [RAIL_W-1:0] RAIL_ISOLATED = RAIL_W'(1);
   localparam logic [RAIL_W-1:0] RAIL_SWITCH1  = RAIL_W'(2);
   localparam logic [RAIL_W-1:0] LAST_RAIL     = RAIL_W'(RAIL_COUNT - 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_WINDOW = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_READY_DEBOUNCE = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_LOSS_DEBOUNCE = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_MAIN = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_ISOLATED = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_SWITCH = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_AUX_PRESENT = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_SWITCH_ON_MAX = CSR_IDX_W'(7);

   // register reset values
   localparam logic [CFG_W-1:0] SETTLE_WINDOW_RST    = CFG_W'(10);
   localparam logic [CFG_W-1:0] READY_DEBOUNCE_RST   = CFG_W'(20);
   localparam logic [CFG_W-1:0] LOSS_DEBOUNCE_RST    = CFG_W'(20);
   localparam logic [CFG_W-1:0] TIMEOUT_MAIN_RST     = CFG_W'(500);
   localparam logic [CFG_W-1:0] TIMEOUT_ISOLATED_RST = CFG_W'(500);
   localparam logic [CFG_W-1:0] TIMEOUT_SWITCH_RST   = CFG_W'(200);
   localparam logic [CFG_W-1:0] AUX_PRESENT_RST      = CFG_W'(18000);
   localparam logic [CFG_W-1:0] SWITCH_ON_MAX_RST    = CFG_W'(2000);

   localparam logic [RAIL_COUNT-1:0] ALL_RAILS = '1;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_REQUEST = 3'd1,
      OP_FORCE   = 3'd2,
      OP_CLEAR   = 3'd3,
      OP_ESTOP   = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      PH_OFF      = 4'b0001,
      PH_ENABLING = 4'b0010,
      PH_ON       = 4'b0100,
      PH_LATCHED  = 4'b1000
   } phase_type;

   typedef struct packed {
      op_type          op;
      logic            chosen;
      logic            pre;
      logic            good;
      logic            desired;
      logic            latched;
      phase_type       phase;
      logic [CFG_W-1:0] elapsed;
      logic [CFG_W-1:0] timeout_lim;
   } rail_ctl_type;

   typedef struct packed {
      phase_type phase;
      logic      desired;
      logic      latched;
   } rail_res_type;

endpackage

// File: rtl/power_rail_sequencer.sv
// ----------------------------------------------------------------------------
// power_rail_sequencer
// Supervisor and sequencer for four dependent power rails.
// ----------------------------------------------------------------------------
// Each request steps through the rails in order 0 to 3, one rail at a time:
// the rail's four timing counters live in one counter memory entry that is
// read ahead, updated and written back, so the memory port sets the rate.
// A new request is taken in the cycle the last rail of the previous one
// completes; the result sits in an output register while the next request
// runs. A stalled result holds the last rail step. The counter memory needs
// no clearing after reset: a rail's counters are zeroed whenever it enters
// the enabling or on phase, the only phases that use them.
module power_rail_sequencer
   import prs_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_operation,
   input  logic [RAIL_COUNT-1:0]   req_rail_mask,
   input  logic [CFG_W-1:0]        req_elapsed_ms,
   input  logic                    req_volt_valid,
   input  logic [CFG_W-1:0]        req_aux_mv,
   input  logic [CFG_W-1:0]        req_switch1_mv,
   input  logic [CFG_W-1:0]        req_switch2_mv,
   input  logic                    req_main_pgood,
   input  logic                    req_isolated_pgood,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [RAIL_COUNT-1:0]   rsp_drive_mask,
   output logic [RAIL_COUNT-1:0]   rsp_on_mask,
   output logic [RAIL_COUNT-1:0]   rsp_fault_mask,
   output logic [RAIL_COUNT-1:0]   rsp_wanted_mask,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CFG_W-1:0]        csr_data
);

   localparam int CW  = COUNTER_WIDTH;
   localparam int MEM_W = 4 * CW;

   // configuration
   logic [CFG_W-1:0] settle_window_ff, ready_debounce_ff, loss_debounce_ff;
   logic [CFG_W-1:0] timeout_main_ff, timeout_isolated_ff, timeout_switch_ff;
   logic [CFG_W-1:0] aux_present_ff, switch_on_max_ff;

   // sequencer control
   logic                busy_ff, busy_in;
   logic [RAIL_W-1:0]   step_ff, step_in;
   logic                accept, advance, final_step, out_free;
   logic [RAIL_W-1:0]   rd_addr;

   // captured request
   op_type                item_op_ff;
   logic [RAIL_COUNT-1:0] item_mask_ff;
   logic [CFG_W-1:0]      item_dt_ff, item_aux_ff, item_sw1_ff, item_sw2_ff;
   logic                  item_volt_ff, item_pg_main_ff, item_pg_iso_ff, item_main_on_ff;

   // rail state
   phase_type             phase_ff [RAIL_COUNT];
   phase_type             phase_in [RAIL_COUNT];
   logic [RAIL_COUNT-1:0] desired_ff, desired_in, latched_ff, latched_in;

   // counter memory
   logic [MEM_W-1:0] cnt_mem [RAIL_COUNT];
   logic [MEM_W-1:0] rd_data_ff;
   logic [MEM_W-1:0] wr_data;

   // result register
   logic                  rsp_valid_ff;
   logic [RAIL_COUNT-1:0] drive_ff, on_ff, fault_ff, wanted_ff;
   logic [RAIL_COUNT-1:0] drive_in, on_in, latched_phase;

   rail_ctl_type     ctl;
   rail_res_type     res;
   logic [CW-1:0]    settle_nxt, timeout_nxt, stable_nxt, loss_nxt;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_window_ff    <= SETTLE_WINDOW_RST;
         ready_debounce_ff   <= READY_DEBOUNCE_RST;
         loss_debounce_ff    <= LOSS_DEBOUNCE_RST;
         timeout_main_ff     <= TIMEOUT_MAIN_RST;
         timeout_isolated_ff <= TIMEOUT_ISOLATED_RST;
         timeout_switch_ff   <= TIMEOUT_SWITCH_RST;
         aux_present_ff      <= AUX_PRESENT_RST;
         switch_on_max_ff    <= SWITCH_ON_MAX_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SETTLE_WINDOW:    settle_window_ff    <= csr_data;
            CSR_READY_DEBOUNCE:   ready_debounce_ff   <= csr_data;
            CSR_LOSS_DEBOUNCE:    loss_debounce_ff    <= csr_data;
            CSR_TIMEOUT_MAIN:     timeout_main_ff     <= csr_data;
            CSR_TIMEOUT_ISOLATED: timeout_isolated_ff <= csr_data;
            CSR_TIMEOUT_SWITCH:   timeout_switch_ff   <= csr_data;
            CSR_AUX_PRESENT:      aux_present_ff      <= csr_data;
            CSR_SWITCH_ON_MAX:    switch_on_max_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // handshake and step sequencing
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = busy_ff && ((step_ff != LAST_RAIL) || out_free);
   assign final_step = advance && (step_ff == LAST_RAIL);
   assign req_stall  = busy_ff && !final_step;
   assign accept     = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         step_in = '0;
         busy_in = 1'b1;
      end else if (advance) begin
         step_in = step_ff + RAIL_W'(1);
         busy_in = !final_step;
      end else begin
         step_in = step_ff;
         busy_in = busy_ff;
      end
      rd_addr = step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_op_ff      <= op_type'(req_operation);
         item_mask_ff    <= req_rail_mask;
         item_dt_ff      <= req_elapsed_ms;
         item_volt_ff    <= req_volt_valid;
         item_aux_ff     <= req_aux_mv;
         item_sw1_ff     <= req_switch1_mv;
         item_sw2_ff     <= req_switch2_mv;
         item_pg_main_ff <= req_main_pgood;
         item_pg_iso_ff  <= req_isolated_pgood;
         item_main_on_ff <= (phase_ff[RAIL_MAIN] == PH_ON);
      end
   end

   // counter memory: read one rail ahead, write back the rail just computed
   always_ff @(posedge clock) begin
      if (advance) begin
         cnt_mem[step_ff] <= wr_data;
      end
      rd_data_ff <= cnt_mem[rd_addr];
   end

   // per-rail inputs
   always_comb begin
      ctl.op       = item_op_ff;
      ctl.chosen   = item_mask_ff[step_ff];
      ctl.desired  = desired_ff[step_ff];
      ctl.latched  = latched_ff[step_ff];
      ctl.phase    = phase_ff[step_ff];
      ctl.elapsed  = item_dt_ff;
      case (step_ff)
         RAIL_MAIN: begin
            ctl.pre         = item_volt_ff && (item_aux_ff >= aux_present_ff);
            ctl.good        = item_pg_main_ff;
            ctl.timeout_lim = timeout_main_ff;
         end
         RAIL_ISOLATED: begin
            ctl.pre         = item_main_on_ff;
            ctl.good        = item_pg_iso_ff;
            ctl.timeout_lim = timeout_isolated_ff;
         end
         RAIL_SWITCH1: begin
            ctl.pre         = item_main_on_ff && item_volt_ff;
            ctl.good        = item_volt_ff && (item_sw1_ff < switch_on_max_ff);
            ctl.timeout_lim = timeout_switch_ff;
         end
         default: begin
            ctl.pre         = item_main_on_ff && item_volt_ff;
            ctl.good        = item_volt_ff && (item_sw2_ff < switch_on_max_ff);
            ctl.timeout_lim = timeout_switch_ff;
         end
      endcase
   end

   prs_rail_unit #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_rail (
      .ctl            (ctl),
      .settle_window  (settle_window_ff),
      .ready_debounce (ready_debounce_ff),
      .loss_debounce  (loss_debounce_ff),
      .settle_cnt     (rd_data_ff[0*CW +: CW]),
      .timeout_cnt    (rd_data_ff[1*CW +: CW]),
      .stable_cnt     (rd_data_ff[2*CW +: CW]),
      .loss_cnt       (rd_data_ff[3*CW +: CW]),
      .res            (res),
      .settle_nxt     (settle_nxt),
      .timeout_nxt    (timeout_nxt),
      .stable_nxt     (stable_nxt),
      .loss_nxt       (loss_nxt)
   );

   assign wr_data = {loss_nxt, stable_nxt, timeout_nxt, settle_nxt};

   always_comb begin
      for (int r = 0; r < RAIL_COUNT; r++) begin
         phase_in[r] = phase_ff[r];
      end
      desired_in = desired_ff;
      latched_in = latched_ff;
      if (advance) begin
         phase_in[step_ff]   = res.phase;
         desired_in[step_ff] = res.desired;
         latched_in[step_ff] = res.latched;
      end
      for (int r = 0; r < RAIL_COUNT; r++) begin
         drive_in[r]      = (phase_in[r] == PH_ENABLING) || (phase_in[r] == PH_ON);
         on_in[r]         = (phase_in[r] == PH_ON);
         latched_phase[r] = (phase_ff[r] == PH_LATCHED);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < RAIL_COUNT; r++) begin
            phase_ff[r] <= PH_OFF;
         end
         desired_ff <= ALL_RAILS;
         latched_ff <= '0;
      end else begin
         for (int r = 0; r < RAIL_COUNT; r++) begin
            phase_ff[r] <= phase_in[r];
         end
         desired_ff <= desired_in;
         latched_ff <= latched_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (final_step) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (final_step) begin
         drive_ff  <= drive_in;
         on_ff     <= on_in;
         fault_ff  <= latched_in;
         wanted_ff <= desired_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_mask  = drive_ff;
   assign rsp_on_mask     = on_ff;
   assign rsp_fault_mask  = fault_ff;
   assign rsp_wanted_mask = wanted_ff;

   // checks
   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      advance |-> (rd_addr != step_ff))
      else $error("counter memory read and write hit the same rail");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy_ff && (step_ff == '0)))
      else $error("accepted request did not start at rail 0");

   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(final_step))
      else $error("result raised without a completed request");

   a_latched_phase: assert property (@(posedge clock) disable iff (reset)
      (latched_phase & ~latched_ff) == '0)
      else $error("rail in latched phase without its fault bit");

   a_masks_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (((rsp_on_mask & ~rsp_drive_mask) == '0)
                        && ((rsp_drive_mask & rsp_fault_mask) == '0)))
      else $error("inconsistent drive, on and fault masks");

endmodule

// File: rtl/prs_rail_unit.sv
// ----------------------------------------------------------------------------
// prs_rail_unit
// Next state of one rail: phase, desired and latched bits and its counters.
// ----------------------------------------------------------------------------
module prs_rail_unit
   import prs_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
   input  rail_ctl_type             ctl,
   input  logic [CFG_W-1:0]         settle_window,
   input  logic [CFG_W-1:0]         ready_debounce,
   input  logic [CFG_W-1:0]         loss_debounce,
   input  logic [COUNTER_WIDTH-1:0] settle_cnt,
   input  logic [COUNTER_WIDTH-1:0] timeout_cnt,
   input  logic [COUNTER_WIDTH-1:0] stable_cnt,
   input  logic [COUNTER_WIDTH-1:0] loss_cnt,
   output rail_res_type             res,
   output logic [COUNTER_WIDTH-1:0] settle_nxt,
   output logic [COUNTER_WIDTH-1:0] timeout_nxt,
   output logic [COUNTER_WIDTH-1:0] stable_nxt,
   output logic [COUNTER_WIDTH-1:0] loss_nxt
);

   localparam int SUM_W = ((COUNTER_WIDTH > CFG_W) ? COUNTER_WIDTH : CFG_W) + 1;
   localparam logic [SUM_W-1:0] CAP = SUM_W'({COUNTER_WIDTH{1'b1}});

   logic                     allowed;
   logic                     settling;
   logic [COUNTER_WIDTH-1:0] add_op;
   logic [SUM_W-1:0]         sum;
   logic [COUNTER_WIDTH-1:0] sat;
   logic [CFG_W-1:0]         thr;
   logic                     reached;

   // one shared saturating adder and threshold compare
   assign allowed  = ctl.desired && !ctl.latched;
   assign settling = SUM_W'(settle_cnt) < SUM_W'(settle_window);

   always_comb begin
      if (ctl.phase == PH_ON) begin
         add_op = loss_cnt;
         thr    = loss_debounce;
      end else if (settling) begin
         add_op = settle_cnt;
         thr    = ready_debounce;
      end else if (ctl.good) begin
         add_op = stable_cnt;
         thr    = ready_debounce;
      end else begin
         add_op = timeout_cnt;
         thr    = ctl.timeout_lim;
      end
   end

   assign sum     = SUM_W'(add_op) + SUM_W'(ctl.elapsed);
   assign sat     = (sum > CAP) ? COUNTER_WIDTH'(CAP) : COUNTER_WIDTH'(sum);
   assign reached = SUM_W'(sat) >= SUM_W'(thr);

   always_comb begin
      res.phase   = ctl.phase;
      res.desired = ctl.desired;
      res.latched = ctl.latched;
      settle_nxt  = settle_cnt;
      timeout_nxt = timeout_cnt;
      stable_nxt  = stable_cnt;
      loss_nxt    = loss_cnt;
      case (ctl.op)
         OP_TICK: begin
            case (ctl.phase)
               PH_OFF: begin
                  if (allowed && ctl.pre) begin
                     res.phase = PH_ENABLING;
                     settle_nxt = '0; timeout_nxt = '0; stable_nxt = '0; loss_nxt = '0;
                  end
               end
               PH_ENABLING: begin
                  if (!allowed) begin
                     res.phase = PH_OFF;
                     settle_nxt = '0; timeout_nxt = '0; stable_nxt = '0; loss_nxt = '0;
                  end else if (settling) begin
                     settle_nxt  = sat;
                     stable_nxt  = '0;
                     timeout_nxt = '0;
                  end else if (!ctl.pre) begin
                     stable_nxt = '0;
                  end else if (ctl.good) begin
                     stable_nxt = sat;
                     if (reached) begin
                        res.phase = PH_ON;
                        settle_nxt = '0; timeout_nxt = '0; stable_nxt = '0; loss_nxt = '0;
                     end
                  end else begin
                     stable_nxt  = '0;
                     timeout_nxt = sat;
                     if (reached) begin
                        res.phase   = PH_LATCHED;
                        res.latched = 1'b1;
                        settle_nxt = '0; timeout_nxt = '0; stable_nxt = '0; loss_nxt = '0;
                     end
                  end
               end
               PH_ON: begin
                  if (!allowed) begin
                     res.phase = PH_OFF;
                     settle_nxt = '0; timeout_nxt = '0; stable_nxt = '0; loss_nxt = '0;
                  end else if (ctl.good) begin
                     loss_nxt = '0;
                  end else begin
                     loss_nxt = sat;
                     if (reached) begin
                        res.phase   = PH_LATCHED;
                        res.latched = 1'b1;
                        settle_nxt = '0; timeout_nxt = '0; stable_nxt = '0; loss_nxt = '0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         OP_REQUEST: begin
            res.desired = ctl.chosen;
            if (!ctl.chosen) begin
               res.latched = 1'b0;
               res.phase   = PH_OFF;
               settle_nxt = '0; timeout_nxt = '0; stable_nxt = '0; loss_nxt = '0;
            end
         end
         OP_FORCE: begin
            if (ctl.chosen) begin
               res.latched = 1'b1;
               res.phase   = PH_LATCHED;
               settle_nxt = '0; timeout_nxt = '0; stable_nxt = '0; loss_nxt = '0;
            end
         end
         OP_CLEAR: begin
            res.latched = 1'b0;
            if (ctl.phase == PH_LATCHED) begin
               res.phase = PH_OFF;
            end
         end
         OP_ESTOP: begin
            res.desired = 1'b0;
            res.phase   = PH_OFF;
            settle_nxt = '0; timeout_nxt = '0; stable_nxt = '0; loss_nxt = '0;
         end
         default: begin
         end
      endcase
   end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for power_rail_sequencer. A driver feeds requests
// (ticks and commands) from a queue with random idle bursts; a monitor
// predicts the rail status after each accepted request and checks every
// result field against it. Register settings change between phases,
// with both extremes of every register included.
// ----------------------------------------------------------------------------
module tb;
   import prs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int OP_CODES = 2 ** $bits(op_type);
   localparam int CSR_REGS = int'(CSR_SWITCH_ON_MAX) + 1;

   typedef struct packed {
      logic [2:0]            op;
      logic [RAIL_COUNT-1:0] mask;
      logic [CFG_W-1:0]      elapsed;
      logic                  volt_ok;
      logic [CFG_W-1:0]      aux;
      logic [CFG_W-1:0]      sw1;
      logic [CFG_W-1:0]      sw2;
      logic                  pg_main;
      logic                  pg_iso;
   } rail_cmd_type;

   typedef struct packed {
      logic [RAIL_COUNT-1:0] drive;
      logic [RAIL_COUNT-1:0] on;
      logic [RAIL_COUNT-1:0] fault;
      logic [RAIL_COUNT-1:0] wanted;
   } rail_status_type;

   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  req_valid          = 1'b0;
   logic                  req_stall;
   logic [2:0]            req_operation      = '0;
   logic [RAIL_COUNT-1:0] req_rail_mask      = '0;
   logic [CFG_W-1:0]      req_elapsed_ms     = '0;
   logic                  req_volt_valid     = 1'b0;
   logic [CFG_W-1:0]      req_aux_mv         = '0;
   logic [CFG_W-1:0]      req_switch1_mv     = '0;
   logic [CFG_W-1:0]      req_switch2_mv     = '0;
   logic                  req_main_pgood     = 1'b0;
   logic                  req_isolated_pgood = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall          = 1'b0;
   logic [RAIL_COUNT-1:0] rsp_drive_mask;
   logic [RAIL_COUNT-1:0] rsp_on_mask;
   logic [RAIL_COUNT-1:0] rsp_fault_mask;
   logic [RAIL_COUNT-1:0] rsp_wanted_mask;
   logic                  csr_valid          = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index          = '0;
   logic [CFG_W-1:0]      csr_data           = '0;

   power_rail_sequencer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_rail_mask      (req_rail_mask),
      .req_elapsed_ms     (req_elapsed_ms),
      .req_volt_valid     (req_volt_valid),
      .req_aux_mv         (req_aux_mv),
      .req_switch1_mv     (req_switch1_mv),
      .req_switch2_mv     (req_switch2_mv),
      .req_main_pgood     (req_main_pgood),
      .req_isolated_pgood (req_isolated_pgood),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive_mask     (rsp_drive_mask),
      .rsp_on_mask        (rsp_on_mask),
      .rsp_fault_mask     (rsp_fault_mask),
      .rsp_wanted_mask    (rsp_wanted_mask),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // rail supervisor mirror
   phase_type             rail_ph   [RAIL_COUNT];
   logic [CFG_W-1:0]      settle_ms [RAIL_COUNT];
   logic [CFG_W-1:0]      wait_ms   [RAIL_COUNT];
   logic [CFG_W-1:0]      good_ms   [RAIL_COUNT];
   logic [CFG_W-1:0]      bad_ms    [RAIL_COUNT];
   logic [RAIL_COUNT-1:0] want_bits;
   logic [RAIL_COUNT-1:0] fault_bits;
   logic [CFG_W-1:0]      csr_shadow [CSR_REGS];

   rail_cmd_type    cmd_queue  [$];
   rail_status_type status_due [$];

   logic req_fire  = 1'b0;
   logic csr_fire  = 1'b0;
   logic drv_valid = 1'b0;
   logic quiet     = 1'b0;
   int   idle_pct  = 0;
   int   send_gap  = 0;
   int   stall_left = 0;
   int   errors    = 0;
   int   n_results = 0;
   int   n_writes  = 0;
   int   n_settings = 0;
   int   n_op [OP_CODES];

   function automatic logic [CFG_W-1:0] sat_sum(logic [CFG_W-1:0] a, logic [CFG_W-1:0] b);
      logic [CFG_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CFG_W] ? '1 : s[CFG_W-1:0];
   endfunction

   function automatic void zero_counts(int r);
      settle_ms[r] = '0;
      wait_ms[r]   = '0;
      good_ms[r]   = '0;
      bad_ms[r]    = '0;
   endfunction

   function automatic void trip_rail(int r);
      fault_bits[r] = 1'b1;
      zero_counts(r);
      rail_ph[r] = PH_LATCHED;
   endfunction

   function automatic void step_rail(int r, logic pre, logic good, logic [CFG_W-1:0] dt);
      logic             allowed;
      logic [CFG_W-1:0] limit;
      allowed = want_bits[r] && !fault_bits[r];
      if (r == RAIL_MAIN) limit = csr_shadow[CSR_TIMEOUT_MAIN];
      else if (r == RAIL_ISOLATED) limit = csr_shadow[CSR_TIMEOUT_ISOLATED];
      else limit = csr_shadow[CSR_TIMEOUT_SWITCH];
      case (rail_ph[r])
         PH_OFF: begin
            if (allowed && pre) begin
               zero_counts(r);
               rail_ph[r] = PH_ENABLING;
            end
         end
         PH_ENABLING: begin
            if (!allowed) begin
               zero_counts(r);
               rail_ph[r] = PH_OFF;
            end else if (settle_ms[r] < csr_shadow[CSR_SETTLE_WINDOW]) begin
               settle_ms[r] = sat_sum(settle_ms[r], dt);
               good_ms[r] = '0;
               wait_ms[r] = '0;
            end else if (!pre) begin
               good_ms[r] = '0;
            end else if (good) begin
               good_ms[r] = sat_sum(good_ms[r], dt);
               if (good_ms[r] >= csr_shadow[CSR_READY_DEBOUNCE]) begin
                  zero_counts(r);
                  rail_ph[r] = PH_ON;
               end
            end else begin
               good_ms[r] = '0;
               wait_ms[r] = sat_sum(wait_ms[r], dt);
               if (wait_ms[r] >= limit) trip_rail(r);
            end
         end
         PH_ON: begin
            if (!allowed) begin
               zero_counts(r);
               rail_ph[r] = PH_OFF;
            end else if (good) begin
               bad_ms[r] = '0;
            end else begin
               bad_ms[r] = sat_sum(bad_ms[r], dt);
               if (bad_ms[r] >= csr_shadow[CSR_LOSS_DEBOUNCE]) trip_rail(r);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void reset_rails();
      for (int r = 0; r < RAIL_COUNT; r++) begin
         rail_ph[r] = PH_OFF;
         zero_counts(r);
      end
      want_bits  = ALL_RAILS;
      fault_bits = '0;
      csr_shadow[CSR_SETTLE_WINDOW]    = SETTLE_WINDOW_RST;
      csr_shadow[CSR_READY_DEBOUNCE]   = READY_DEBOUNCE_RST;
      csr_shadow[CSR_LOSS_DEBOUNCE]    = LOSS_DEBOUNCE_RST;
      csr_shadow[CSR_TIMEOUT_MAIN]     = TIMEOUT_MAIN_RST;
      csr_shadow[CSR_TIMEOUT_ISOLATED] = TIMEOUT_ISOLATED_RST;
      csr_shadow[CSR_TIMEOUT_SWITCH]   = TIMEOUT_SWITCH_RST;
      csr_shadow[CSR_AUX_PRESENT]      = AUX_PRESENT_RST;
      csr_shadow[CSR_SWITCH_ON_MAX]    = SWITCH_ON_MAX_RST;
   endfunction

   function automatic rail_status_type predict_status(rail_cmd_type c);
      rail_status_type  s;
      logic             main_was_on;
      logic [CFG_W-1:0] sw_max;
      sw_max = csr_shadow[CSR_SWITCH_ON_MAX];
      case (c.op)
         OP_TICK: begin
            // dependent rails see rail 0 as it was at the start of the tick
            main_was_on = rail_ph[RAIL_MAIN] == PH_ON;
            step_rail(RAIL_MAIN, c.volt_ok && c.aux >= csr_shadow[CSR_AUX_PRESENT],
                      c.pg_main, c.elapsed);
            step_rail(RAIL_ISOLATED, main_was_on, c.pg_iso, c.elapsed);
            step_rail(RAIL_SWITCH1, main_was_on && c.volt_ok,
                      c.volt_ok && c.sw1 < sw_max, c.elapsed);
            step_rail(LAST_RAIL, main_was_on && c.volt_ok,
                      c.volt_ok && c.sw2 < sw_max, c.elapsed);
         end
         OP_REQUEST: begin
            want_bits = c.mask;
            for (int r = 0; r < RAIL_COUNT; r++) begin
               if (!c.mask[r]) begin
                  fault_bits[r] = 1'b0;
                  if (rail_ph[r] != PH_OFF) begin
                     zero_counts(r);
                     rail_ph[r] = PH_OFF;
                  end
               end
            end
         end
         OP_FORCE: begin
            for (int r = 0; r < RAIL_COUNT; r++)
               if (c.mask[r]) trip_rail(r);
         end
         OP_CLEAR: begin
            fault_bits = '0;
            for (int r = 0; r < RAIL_COUNT; r++)
               if (rail_ph[r] == PH_LATCHED) rail_ph[r] = PH_OFF;
         end
         OP_ESTOP: begin
            want_bits = '0;
            for (int r = 0; r < RAIL_COUNT; r++) begin
               zero_counts(r);
               rail_ph[r] = PH_OFF;
            end
         end
         default: ;
      endcase
      for (int r = 0; r < RAIL_COUNT; r++) begin
         s.drive[r] = rail_ph[r] == PH_ENABLING || rail_ph[r] == PH_ON;
         s.on[r]    = rail_ph[r] == PH_ON;
      end
      s.fault  = fault_bits;
      s.wanted = want_bits;
      return s;
   endfunction

   task automatic check_field(string name, logic [RAIL_COUNT-1:0] want,
                              logic [RAIL_COUNT-1:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         errors++;
      end
   endtask

   // monitor: predict on request accept, check on result accept
   always @(posedge clock) begin
      rail_cmd_type    c;
      rail_status_type exp_s;
      if (reset) begin
         reset_rails();
         req_fire <= 1'b0;
         csr_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         csr_fire <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) begin
            n_writes++;
            if (csr_index <= CSR_SWITCH_ON_MAX) csr_shadow[csr_index] = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (status_due.size() == 0) begin
               $error("result with no request outstanding");
               errors++;
            end else begin
               exp_s = status_due.pop_front();
               check_field("drive_mask", exp_s.drive, rsp_drive_mask);
               check_field("on_mask", exp_s.on, rsp_on_mask);
               check_field("fault_mask", exp_s.fault, rsp_fault_mask);
               check_field("wanted_mask", exp_s.wanted, rsp_wanted_mask);
            end
         end
         if (req_valid && !req_stall) begin
            c = '{req_operation, req_rail_mask, req_elapsed_ms, req_volt_valid, req_aux_mv,
                  req_switch1_mv, req_switch2_mv, req_main_pgood, req_isolated_pgood};
            n_op[c.op]++;
            status_due.push_back(predict_status(c));
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      rail_cmd_type nxt;
      if (!reset && !(drv_valid && !req_fire)) begin
         if (send_gap > 0) begin
            send_gap--;
            drv_valid = 1'b0;
         end else if (cmd_queue.size() == 0) begin
            drv_valid = 1'b0;
         end else if (!quiet && $urandom_range(99) < idle_pct) begin
            send_gap = $urandom_range(4);
            drv_valid = 1'b0;
         end else begin
            nxt = cmd_queue.pop_front();
            drv_valid = 1'b1;
            req_operation      <= nxt.op;
            req_rail_mask      <= nxt.mask;
            req_elapsed_ms     <= nxt.elapsed;
            req_volt_valid     <= nxt.volt_ok;
            req_aux_mv         <= nxt.aux;
            req_switch1_mv     <= nxt.sw1;
            req_switch2_mv     <= nxt.sw2;
            req_main_pgood     <= nxt.pg_main;
            req_isolated_pgood <= nxt.pg_iso;
         end
         req_valid <= drv_valid;
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(99) < idle_pct) begin
         stall_left = $urandom_range(4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic rail_cmd_type cmd(logic [2:0] op, logic [RAIL_COUNT-1:0] mask,
                                        logic [CFG_W-1:0] dt, logic vv, logic [CFG_W-1:0] aux,
                                        logic [CFG_W-1:0] sw1, logic [CFG_W-1:0] sw2,
                                        logic pgm, logic pgi);
      return '{op, mask, dt, vv, aux, sw1, sw2, pgm, pgi};
   endfunction

   function automatic rail_cmd_type good_tick(logic [CFG_W-1:0] dt);
      return cmd(OP_TICK, '0, dt, 1'b1, '1, '0, '0, 1'b1, 1'b1);
   endfunction

   function automatic rail_cmd_type random_cmd();
      rail_cmd_type     c;
      int               roll;
      logic [CFG_W-1:0] sw_max;
      c.op      = 3'($urandom);
      c.mask    = RAIL_COUNT'($urandom);
      c.elapsed = CFG_W'($urandom);
      c.volt_ok = 1'($urandom);
      c.aux     = CFG_W'($urandom);
      c.sw1     = CFG_W'($urandom);
      c.sw2     = CFG_W'($urandom);
      c.pg_main = 1'($urandom);
      c.pg_iso  = 1'($urandom);
      roll = $urandom_range(99);
      sw_max = csr_shadow[CSR_SWITCH_ON_MAX];
      if (roll < 10) begin
         return c;
      end else if (roll < 72) begin
         c.op = OP_TICK;
         roll = $urandom_range(9);
         if (roll > 2) c.elapsed = CFG_W'($urandom_range(30));
         else if (roll > 0) c.elapsed = CFG_W'($urandom_range(1000));
         c.volt_ok = $urandom_range(9) != 0;
         if ($urandom_range(4) != 0)
            c.aux = CFG_W'($urandom_range(16'hFFFF, csr_shadow[CSR_AUX_PRESENT]));
         if (sw_max != 0 && $urandom_range(4) != 0)
            c.sw1 = CFG_W'($urandom_range(sw_max - 1));
         if (sw_max != 0 && $urandom_range(4) != 0)
            c.sw2 = CFG_W'($urandom_range(sw_max - 1));
         c.pg_main = $urandom_range(7) != 0;
         c.pg_iso  = $urandom_range(7) != 0;
      end else if (roll < 82) begin
         c.op = OP_REQUEST;
         if ($urandom_range(1)) c.mask = ALL_RAILS;
      end else if (roll < 89) begin
         c.op = OP_CLEAR;
      end else if (roll < 94) begin
         c.op = OP_FORCE;
      end else if (roll < 97) begin
         c.op = OP_ESTOP;
      end else begin
         c.op = 3'($urandom_range(OP_CODES - 1, int'(OP_ESTOP) + 1));
      end
      return c;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_fire);
   endtask

   task automatic program_settings(input logic [CFG_W-1:0] vals [CSR_REGS]);
      for (int k = 0; k < CSR_REGS; k++) write_reg(CSR_IDX_W'(k), vals[k]);
      // indexes past the register file must be ignored
      write_reg('1, CFG_W'($urandom));
      write_reg(CSR_IDX_W'($urandom_range(2 ** CSR_IDX_W - 1, CSR_REGS)), CFG_W'($urandom));
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   task automatic wait_drained(int cap);
      int n;
      n = 0;
      do begin
         @(negedge clock);
         n++;
      end while ((cmd_queue.size() != 0 || drv_valid || status_due.size() != 0) && n < cap);
      if (status_due.size() != 0) begin
         $error("%0d results never arrived", status_due.size());
         errors += status_due.size();
         status_due.delete();
      end
   endtask

   task automatic load_directed();
      cmd_queue.push_back(cmd(OP_TICK, '0, '0, 1'b1, '1, '0, '0, 1'b1, 1'b1));
      cmd_queue.push_back(cmd(OP_TICK, '1, '1, 1'b1, '1, '1, '1, 1'b1, 1'b1));
      cmd_queue.push_back(good_tick('1));
      cmd_queue.push_back(good_tick(16'd1));
      cmd_queue.push_back(good_tick(16'd10));
      cmd_queue.push_back(good_tick(16'd25));
      cmd_queue.push_back(cmd(OP_TICK, '0, 16'd5, 1'b1, '0, '0, '0, 1'b0, 1'b1));
      cmd_queue.push_back(good_tick(16'd5));
      cmd_queue.push_back(cmd(OP_TICK, '0, 16'd30, 1'b0, '0, '1, '1, 1'b0, 1'b0));
      for (int k = int'(OP_ESTOP) + 1; k < OP_CODES; k++)
         cmd_queue.push_back(cmd(3'(k), '1, '1, 1'b1, '1, '1, '1, 1'b1, 1'b1));
      cmd_queue.push_back(cmd(OP_CLEAR, '0, '0, 1'b0, '0, '0, '0, 1'b0, 1'b0));
      cmd_queue.push_back(cmd(OP_FORCE, 4'b1010, '0, 1'b0, '0, '0, '0, 1'b0, 1'b0));
      cmd_queue.push_back(cmd(OP_REQUEST, 4'b0101, '0, 1'b0, '0, '0, '0, 1'b0, 1'b0));
      cmd_queue.push_back(cmd(OP_REQUEST, '0, '0, 1'b0, '0, '0, '0, 1'b0, 1'b0));
      cmd_queue.push_back(cmd(OP_ESTOP, '1, '0, 1'b0, '0, '0, '0, 1'b0, 1'b0));
      cmd_queue.push_back(cmd(OP_REQUEST, '1, '0, 1'b0, '0, '0, '0, 1'b0, 1'b0));
      cmd_queue.push_back(cmd(OP_TICK, '0, 16'd3, 1'b0, '1, '0, '0, 1'b1, 1'b1));
      // rail 0 on, dependents settle, then rail 0 is lost under them
      repeat (5) cmd_queue.push_back(good_tick('1));
      cmd_queue.push_back(cmd(OP_FORCE, 4'b0001, '0, 1'b0, '0, '0, '0, 1'b0, 1'b0));
      cmd_queue.push_back(good_tick('1));
   endtask

   initial begin
      logic [CFG_W-1:0] plan [4][CSR_REGS];
      logic [CFG_W-1:0] calm [CSR_REGS];
      int               pct  [4];
      plan[0] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF};
      plan[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF};
      plan[2] = '{16'd3, 16'd5, 16'd4, 16'd30, 16'd40, 16'd25, 16'd12000, 16'd0};
      for (int k = 0; k < CSR_REGS; k++)
         plan[3][k] = CFG_W'((k < int'(CSR_AUX_PRESENT)) ? $urandom_range(100)
                                                         : $urandom_range(30000));
      calm = '{16'd2, 16'd8, 16'd6, 16'd60, 16'd60, 16'd40, 16'd18000, 16'd2000};
      pct = '{0, 40, 20, 50};
      foreach (n_op[k]) n_op[k] = 0;

      repeat (5) @(negedge clock);
      load_directed();
      repeat (100) cmd_queue.push_back(random_cmd());
      idle_pct = 30;
      reset <= 1'b0;
      wait_drained(20000);

      for (int p = 0; p < 4; p++) begin
         program_settings(plan[p]);
         idle_pct = pct[p];
         repeat (80) cmd_queue.push_back(random_cmd());
         wait_drained(20000);
      end

      program_settings(calm);
      quiet = 1'b1;
      repeat (80) cmd_queue.push_back(random_cmd());
      wait_drained(20000);
      repeat (20) @(negedge clock);

      $display("Covered %0d ticks, %0d output requests, %0d forced latches, %0d clears,",
               n_op[OP_TICK], n_op[OP_REQUEST], n_op[OP_FORCE], n_op[OP_CLEAR]);
      $display("%0d emergency stops and %0d spare codes; %0d results over %0d settings.",
               n_op[OP_ESTOP], n_op[5] + n_op[6] + n_op[7], n_results, n_settings);
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
